### hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; each macro checks one property on the rising clock edge
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// consequent must follow an antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

`endif

### hw/rtl/psns_pkg.sv
// shared types and constants of the point stack nearest search unit
// no dependencies; imported by the controller, datapath, square root and top level
package psns_pkg;

    // stack geometry
    localparam int DEPTH     = 128;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);

    // field widths of the interface
    localparam int COORD_W   = 16;
    localparam int PT_W      = 2 * COORD_W;
    localparam int OUT_IDX_W = 7;
    localparam int OUT_CNT_W = 8;
    localparam int DIST_W    = 25;

    // distance arithmetic widths
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_PROD_W = 2 * DIFF_W;
    localparam int SQR_W     = SQ_PROD_W - 1;
    localparam int D2_W      = SQR_W + 1;
    localparam int FRAC_W    = 8;
    localparam int SQ_W      = D2_W + 2 * FRAC_W;
    localparam int SQ_STEPS  = (SQ_W + 1) / 2;

    // empty query distance, 100000.0 with 8 fraction bits
    localparam logic [DIST_W-1:0] EMPTY_DIST = DIST_W'(100000 * (1 << FRAC_W));

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        EM_PLAIN,
        EM_EMPTYQ,
        EM_QUERY
    } t_emit;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_SQRT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    push;
        logic    pop;
        logic    q_start;
        logic    scan;
        logic    sqrt_start;
        logic    emit;
        t_emit   emit_sel;
        t_status status;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic last_addr;
        logic pipe_busy;
        logic sqrt_done;
    } t_dp_stat;

endpackage

### hw/rtl/point_stack_nearest_search_unit.sv
// top level of the point stack nearest search unit
// depends on psns_pkg, psns_ctrl and psns_dp
// add, remove and unused codes: result registered in the cycle after acceptance, busy stays low
// query on n points: scan at one point per cycle through the store read port,
// a three-stage distance pipeline, then a 25-step bit-pair square root;
// results cannot be stalled
// synchronous active-low reset clears count, controller and strobe; store undefined
module point_stack_nearest_search_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_op,
    input  logic signed [psns_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [psns_pkg::COORD_W-1:0] i_coord_y,
    output logic                           o_valid,
    output logic [1:0]                     o_status,
    output logic [psns_pkg::OUT_IDX_W-1:0] o_nearest_index,
    output logic [psns_pkg::DIST_W-1:0]    o_distance,
    output logic [psns_pkg::OUT_CNT_W-1:0] o_point_count
);
    import psns_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // controller
    psns_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (t_op'(i_op)),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    // datapath
    psns_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_coord_x       (i_coord_x),
        .i_coord_y       (i_coord_y),
        .o_stat          (w_stat),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_nearest_index (o_nearest_index),
        .o_distance      (o_distance),
        .o_point_count   (o_point_count)
    );

endmodule

### hw/rtl/psns_ram.sv
// generic single write, single read ram with registered read data
// no dependencies; parameters set width and depth
module psns_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/psns_sqrt.sv
// iterative integer square root, one result bit per cycle
// depends on psns_pkg; returns floor(sqrt(value * 65536))
module psns_sqrt (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [psns_pkg::D2_W-1:0]   i_value,
    output logic                    o_done,
    output logic [psns_pkg::DIST_W-1:0] o_root
);
    import psns_pkg::*;

    localparam logic [SQ_W-1:0] BitTop = SQ_W'(1) << (2 * (SQ_STEPS - 1));

    logic [SQ_W-1:0] r_rem, n_rem;
    logic [SQ_W-1:0] r_res, n_res;
    logic [SQ_W-1:0] r_bit;
    logic            r_run;
    logic            r_done;
    logic [SQ_W-1:0] w_trial;

    // one restoring step
    always_comb begin
        w_trial = r_res + r_bit;
        if (r_rem >= w_trial) begin
            n_rem = r_rem - w_trial;
            n_res = (r_res >> 1) + r_bit;
        end else begin
            n_rem = r_rem;
            n_res = r_res >> 1;
        end
    end

    // control of the iteration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && (r_bit == SQ_W'(1))) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // remainder, root and bit position
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {i_value, (2 * FRAC_W)'(0)};
            r_res <= '0;
            r_bit <= BitTop;
        end else if (r_run) begin
            r_rem <= n_rem;
            r_res <= n_res;
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[DIST_W-1:0];

endmodule

### hw/rtl/psns_dp.sv
// datapath: point store, count, distance pipeline, best tracking, results
// depends on psns_pkg, psns_ram and psns_sqrt
module psns_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  psns_pkg::t_dp_cmd              i_cmd,
    input  logic signed [psns_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [psns_pkg::COORD_W-1:0] i_coord_y,
    output psns_pkg::t_dp_stat             o_stat,
    output logic                           o_valid,
    output logic [1:0]                     o_status,
    output logic [psns_pkg::OUT_IDX_W-1:0] o_nearest_index,
    output logic [psns_pkg::DIST_W-1:0]    o_distance,
    output logic [psns_pkg::OUT_CNT_W-1:0] o_point_count
);
    import psns_pkg::*;

    logic [CNT_W-1:0]          r_count, n_count;
    logic [IDX_W-1:0]          r_addr;
    logic signed [COORD_W-1:0] r_qx, r_qy;
    logic [PT_W-1:0]           w_rdata;

    logic                      r_v1, r_v2, r_v3;
    logic [IDX_W-1:0]          r_i1, r_i2, r_i3;
    logic signed [DIFF_W-1:0]  r_dx, r_dy;
    logic signed [SQ_PROD_W-1:0] w_sqx, w_sqy;
    logic [SQR_W-1:0]          r_sqx, r_sqy;
    logic [D2_W-1:0]           w_d2;
    logic [D2_W-1:0]           r_best_d2;
    logic [IDX_W-1:0]          r_best_idx;
    logic                      r_have;

    logic                      w_sqrt_done;
    logic [DIST_W-1:0]         w_root;

    logic                      r_valid;
    t_status                   r_status;
    logic [IDX_W-1:0]          r_idx_out;
    logic [DIST_W-1:0]         r_dist_out;
    logic [CNT_W-1:0]          r_cnt_out;

    // point store
    psns_ram #(.WIDTH(PT_W), .DEPTH(DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata ({i_coord_y, i_coord_x}),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    // stack count
    always_comb begin
        n_count = r_count;
        if (i_cmd.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // query position and scan address
    always_ff @(posedge i_clk) begin
        if (i_cmd.q_start) begin
            r_qx   <= i_coord_x;
            r_qy   <= i_coord_y;
            r_addr <= '0;
        end else if (i_cmd.scan) begin
            r_addr <= r_addr + IDX_W'(1);
        end
    end

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.scan;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // differences, then squares
    assign w_sqx = r_dx * r_dx;
    assign w_sqy = r_dy * r_dy;

    always_ff @(posedge i_clk) begin
        r_i1  <= r_addr;
        r_dx  <= DIFF_W'(r_qx) - DIFF_W'($signed(w_rdata[COORD_W-1:0]));
        r_dy  <= DIFF_W'(r_qy) - DIFF_W'($signed(w_rdata[PT_W-1:COORD_W]));
        r_i2  <= r_i1;
        r_sqx <= w_sqx[SQR_W-1:0];
        r_sqy <= w_sqy[SQR_W-1:0];
        r_i3  <= r_i2;
    end

    // squared distance and strict-less best update
    assign w_d2 = D2_W'(r_sqx) + D2_W'(r_sqy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_cmd.q_start) begin
            r_have <= 1'b0;
        end else if (r_v3) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v3 && (!r_have || (w_d2 < r_best_d2))) begin
            r_best_d2  <= w_d2;
            r_best_idx <= r_i3;
        end
    end

    // square root of the best squared distance
    psns_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_value (r_best_d2),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    // result item
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_status  <= i_cmd.status;
            r_cnt_out <= n_count;
            case (i_cmd.emit_sel)
                EM_EMPTYQ: begin
                    r_idx_out  <= '0;
                    r_dist_out <= EMPTY_DIST;
                end
                EM_QUERY: begin
                    if (w_root >= EMPTY_DIST) begin
                        r_idx_out  <= '0;
                        r_dist_out <= EMPTY_DIST;
                    end else begin
                        r_idx_out  <= r_best_idx;
                        r_dist_out <= w_root;
                    end
                end
                default: begin
                    r_idx_out  <= '0;
                    r_dist_out <= '0;
                end
            endcase
        end
    end

    // status to the controller
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count >= CNT_W'(DEPTH));
    assign o_stat.last_addr = (CNT_W'(r_addr) == (r_count - CNT_W'(1)));
    assign o_stat.pipe_busy = r_v1 | r_v2 | r_v3;
    assign o_stat.sqrt_done = w_sqrt_done;

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_nearest_index = OUT_IDX_W'(r_idx_out);
    assign o_distance      = r_dist_out;
    assign o_point_count   = OUT_CNT_W'(r_cnt_out);

endmodule

### hw/rtl/psns_ctrl.sv
// controller state machine: decodes operations and sequences a query
// depends on psns_pkg and assert_macros.svh
`include "assert_macros.svh"

module psns_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  psns_pkg::t_op      i_op,
    input  psns_pkg::t_dp_stat i_stat,
    output psns_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy
);
    import psns_pkg::*;

    t_state  r_state, n_state;
    t_dp_cmd w_cmd;
    logic    w_accept;

    assign w_accept = i_start && (r_state == S_IDLE);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_op == OP_QUERY) && !i_stat.empty) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.last_addr) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (i_stat.sqrt_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        w_cmd          = '0;
        w_cmd.emit_sel = EM_PLAIN;
        w_cmd.status   = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_op)
                        OP_ADD: begin
                            w_cmd.emit   = 1'b1;
                            w_cmd.push   = !i_stat.full;
                            w_cmd.status = i_stat.full ? ST_FULL : ST_OK;
                        end
                        OP_REMOVE: begin
                            w_cmd.emit   = 1'b1;
                            w_cmd.pop    = !i_stat.empty;
                            w_cmd.status = i_stat.empty ? ST_EMPTY : ST_OK;
                        end
                        OP_QUERY: begin
                            if (i_stat.empty) begin
                                w_cmd.emit     = 1'b1;
                                w_cmd.emit_sel = EM_EMPTYQ;
                                w_cmd.status   = ST_EMPTY;
                            end else begin
                                w_cmd.q_start = 1'b1;
                            end
                        end
                        default: begin
                            w_cmd.emit = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                w_cmd.scan = 1'b1;
            end
            S_DRAIN: begin
                w_cmd.sqrt_start = !i_stat.pipe_busy;
            end
            S_SQRT: begin
                if (i_stat.sqrt_done) begin
                    w_cmd.emit     = 1'b1;
                    w_cmd.emit_sel = EM_QUERY;
                end
            end
            default: begin
                w_cmd = '0;
            end
        endcase
    end

    assign o_cmd  = w_cmd;
    assign o_busy = (r_state != S_IDLE);

    // root only starts once the best distance is final
    `ASSERT_IMPLIES(a_sqrt_after_drain, i_clk, i_rst_n, w_cmd.sqrt_start, !i_stat.pipe_busy)
    // a scan never starts on an empty stack
    `ASSERT_IMPLIES(a_query_nonempty, i_clk, i_rst_n, w_cmd.q_start, !i_stat.empty)
    // store and count change only outside a query
    `ASSERT_ALWAYS(a_no_stack_change_busy, i_clk, i_rst_n,
        !((w_cmd.push || w_cmd.pop) && (r_state != S_IDLE)))

endmodule
